[rtl/thpc_pkg.sv]
// Package for the TLS hello packet classifier.
// Holds the frame summary type, status codes and protocol constants.
// No dependencies.
`default_nettype none
package thpc_pkg;

    localparam int unsigned CNT_W     = 16;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned HIST_LEN  = 12;
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned TDATA_W   = 320;

    localparam logic [CNT_W-1:0] MAX_FRAME_BYTES = 16'hFFFF;
    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  REC_HSHAKE  = 8'h16;
    localparam logic [15:0] VER_MIN     = 16'h0300;
    localparam logic [15:0] VER_MAX     = 16'h0304;
    localparam logic [7:0]  HT_CLIENT   = 8'h01;
    localparam logic [7:0]  HT_SERVER   = 8'h02;
    localparam logic [15:0] PORT_A_RST  = 16'd443;
    localparam logic [15:0] PORT_B_RST  = 16'd8443;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [POS_W-1:0] TCP_V6 = 8'd54;

    typedef enum logic [1:0] {
        CFG_PORT_A = 2'd0,
        CFG_PORT_B = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_HELLO      = 3'd0,
        ST_NOT_TCP    = 3'd1,
        ST_PORTS_CUT  = 3'd2,
        ST_UNWATCHED  = 3'd3,
        ST_NO_RECORD  = 3'd4,
        ST_RECORD_CUT = 3'd5,
        ST_NOT_HELLO  = 3'd6
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [15:0]      eth;
        logic             p23;
        logic             p20;
        logic [POS_W-1:0] tcp;
        logic [POS_W-1:0] pay;
        logic [15:0]      sp;
        logic [15:0]      dp;
        logic [7:0]       rec_type;
        logic [15:0]      ver;
        logic [15:0]      rlen;
        logic [7:0]       ht;
        logic [63:0]      src_hi;
        logic [63:0]      src_lo;
        logic [63:0]      dst_hi;
        logic [63:0]      dst_lo;
        logic [31:0]      v4_dst;
    } frame_info_t;

    typedef struct packed {
        logic        valid;
        frame_info_t info;
    } frame_push_t;

endpackage
`default_nettype wire

[rtl/tls_hello_packet_classifier_unit.sv]
// Top level of the TLS hello packet classifier: front end, queue, back end, registers.
// Depends on thpc_pkg, thpc_front, thpc_queue, thpc_back.
//
//  channel | dir | handshake         | contents
//  s_      | in  | s_tvalid/s_tready | tdata: data_byte[7:0]; tlast: last_byte
//  m_      | out | m_tvalid/m_tready | tuser: status; tdata: see port comment
//  cfg_    | in  | cfg_wr_en         | cfg_index selects port a or b, cfg_wdata
//
// One byte a cycle when not stalled; summaries go via the queue into the result register.
// Frame summaries pass through a two-entry queue, so the input stalls only when
// the queue is full and the result register is held.
// Reset is synchronous; it clears counters, queue and result valid; ports take defaults.
`default_nettype none
module tls_hello_packet_classifier_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // data_byte[7:0]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // is_ipv6[0], client_hello[1], server_hello[2], source_port[18:3],
    // dest_port[34:19], source_addr_high[98:35], source_addr_low[162:99],
    // dest_addr_high[226:163], dest_addr_low[290:227], record_offset[298:291],
    // record_length[314:299], zero[319:315]
    output logic [thpc_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]  m_tuser,   // status[2:0]
    input  wire         cfg_wr_en,
    input  wire [1:0]   cfg_index,
    input  wire [15:0]  cfg_wdata
);
    import thpc_pkg::*;

    logic        accept, q_full, head_valid, pop;
    frame_push_t push;
    frame_info_t head;
    logic [15:0] port_a_reg, port_b_reg;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_a_reg <= PORT_A_RST;
            port_b_reg <= PORT_B_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PORT_A: port_a_reg <= cfg_wdata;
                CFG_PORT_B: port_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    thpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .push      (push)
    );

    thpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    thpc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .port_a     (port_a_reg),
        .port_b     (port_b_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

[rtl/thpc_front.sv]
// Front end: counts frame bytes and captures header fields as they stream past.
// Depends on thpc_pkg.
`default_nettype none
module thpc_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 accept,
    input  wire [7:0]           data_byte,
    input  wire                 last_byte,
    output thpc_pkg::frame_push_t push
);
    import thpc_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       hist_reg [HIST_LEN];
    logic [15:0]      eth_reg, eth_next;
    logic             p23_reg, p23_next, p20_reg, p20_next;
    logic [POS_W-1:0] tcp_reg, tcp_next, pay_reg, pay_next;
    logic [15:0]      sp_reg, sp_next, dp_reg, dp_next;
    logic [7:0]       rt_reg, rt_next, ht_reg, ht_next;
    logic [15:0]      ver_reg, ver_next, rlen_reg, rlen_next;
    logic [63:0]      sh_reg, sh_next, sl_reg, sl_next, dh_reg, dh_next, dl_reg, dl_next;
    logic [31:0]      v4d_reg, v4d_next;
    logic [CNT_W-1:0] tcp_ext, pay_ext;
    logic [3:0]       doff;

    always_comb begin
        eth_next  = eth_reg;
        p23_next  = p23_reg;
        p20_next  = p20_reg;
        tcp_next  = tcp_reg;
        pay_next  = pay_reg;
        sp_next   = sp_reg;
        dp_next   = dp_reg;
        rt_next   = rt_reg;
        ver_next  = ver_reg;
        rlen_next = rlen_reg;
        ht_next   = ht_reg;
        sh_next   = sh_reg;
        sl_next   = sl_reg;
        dh_next   = dh_reg;
        dl_next   = dl_reg;
        v4d_next  = v4d_reg;
        doff      = data_byte[7:4];

        if (count_reg == 16'd13) begin
            eth_next = {hist_reg[0], data_byte};
            if (eth_next == ETH_IPV6) begin
                tcp_next = TCP_V6;
            end
        end
        if (count_reg == 16'd14 && eth_reg == ETH_IPV4) begin
            tcp_next = 8'd14 + {2'b00, data_byte[3:0] & NIBBLE_MASK, 2'b00};
        end
        if (count_reg == 16'd23) p23_next = (data_byte == PROTO_TCP);
        if (count_reg == 16'd20) p20_next = (data_byte == PROTO_TCP);

        if (count_reg >= 16'd22 && count_reg <= 16'd29) sh_next = {sh_reg[55:0], data_byte};
        if (count_reg >= 16'd30 && count_reg <= 16'd37) sl_next = {sl_reg[55:0], data_byte};
        if (count_reg >= 16'd38 && count_reg <= 16'd45) dh_next = {dh_reg[55:0], data_byte};
        if (count_reg >= 16'd46 && count_reg <= 16'd53) dl_next = {dl_reg[55:0], data_byte};
        if (count_reg >= 16'd30 && count_reg <= 16'd33) v4d_next = {v4d_reg[23:0], data_byte};

        tcp_ext = {8'b0, tcp_next};
        if (count_reg == tcp_ext + 16'd3) begin
            sp_next = {hist_reg[2], hist_reg[1]};
            dp_next = {hist_reg[0], data_byte};
        end
        if (count_reg == tcp_ext + 16'd12) begin
            pay_next = tcp_next + {2'b00, doff, 2'b00};
            if (doff == 4'd0) begin
                rt_next   = hist_reg[11];
                ver_next  = {hist_reg[10], hist_reg[9]};
                rlen_next = {hist_reg[8], hist_reg[7]};
                ht_next   = hist_reg[6];
            end else if (doff == 4'd1) begin
                rt_next   = hist_reg[7];
                ver_next  = {hist_reg[6], hist_reg[5]};
                rlen_next = {hist_reg[4], hist_reg[3]};
                ht_next   = hist_reg[2];
            end
        end
        pay_ext = {8'b0, pay_next};
        if (count_reg == pay_ext + 16'd4) begin
            rt_next   = hist_reg[3];
            ver_next  = {hist_reg[2], hist_reg[1]};
            rlen_next = {hist_reg[0], data_byte};
        end
        if (count_reg == pay_ext + 16'd5) begin
            ht_next = data_byte;
        end

        if (last_byte) begin
            count_next = '0;
        end else if (count_reg != MAX_FRAME_BYTES) begin
            count_next = count_reg + 16'd1;
        end else begin
            count_next = count_reg;
        end

        push.valid         = accept && last_byte;
        push.info.len      = (count_reg == MAX_FRAME_BYTES) ? count_reg : count_reg + 16'd1;
        push.info.eth      = eth_next;
        push.info.p23      = p23_next;
        push.info.p20      = p20_next;
        push.info.tcp      = tcp_next;
        push.info.pay      = pay_next;
        push.info.sp       = sp_next;
        push.info.dp       = dp_next;
        push.info.rec_type = rt_next;
        push.info.ver      = ver_next;
        push.info.rlen     = rlen_next;
        push.info.ht       = ht_next;
        push.info.src_hi   = sh_next;
        push.info.src_lo   = sl_next;
        push.info.dst_hi   = dh_next;
        push.info.dst_lo   = dl_next;
        push.info.v4_dst   = v4d_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tcp_reg   <= '0;
            pay_reg   <= '0;
        end else if (accept) begin
            count_reg <= count_next;
            tcp_reg   <= tcp_next;
            pay_reg   <= pay_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_reg[0] <= data_byte;
            for (int i = 1; i < HIST_LEN; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            eth_reg  <= eth_next;
            p23_reg  <= p23_next;
            p20_reg  <= p20_next;
            sp_reg   <= sp_next;
            dp_reg   <= dp_next;
            rt_reg   <= rt_next;
            ver_reg  <= ver_next;
            rlen_reg <= rlen_next;
            ht_reg   <= ht_next;
            sh_reg   <= sh_next;
            sl_reg   <= sl_next;
            dh_reg   <= dh_next;
            dl_reg   <= dl_next;
            v4d_reg  <= v4d_next;
        end
    end

endmodule
`default_nettype wire

[rtl/thpc_queue.sv]
// Two-entry queue of frame summaries between front end and classifier.
// Depends on thpc_pkg.
`default_nettype none
module thpc_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  thpc_pkg::frame_push_t push,
    output logic                  full,
    output logic                  head_valid,
    output thpc_pkg::frame_info_t head,
    input  wire                   pop
);
    import thpc_pkg::*;

    frame_info_t mem_reg [QDEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign full       = (cnt_reg == 2'(QDEPTH));
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push.valid) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)        rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push.valid) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.info;
        end
    end

endmodule
`default_nettype wire

[rtl/thpc_back.sv]
// Back end: classifies one frame summary and holds the result for transfer.
// Depends on thpc_pkg.
`default_nettype none
module thpc_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   head_valid,
    input  thpc_pkg::frame_info_t head,
    output logic                  pop,
    input  wire [15:0]            port_a,
    input  wire [15:0]            port_b,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [thpc_pkg::TDATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser
);
    import thpc_pkg::*;

    logic                 valid_reg;
    logic [TDATA_W-1:0]   data_reg, data_next;
    status_t              st_reg, st;
    logic                 v4, v6, ip_ok;
    logic [CNT_W-1:0]     tcp_e, pay_e, plen;
    logic [CNT_W:0]       rec_end;
    logic                 is6, ch, sh;
    logic [15:0]          sp, dp, rl;
    logic [63:0]          sah, sal, dah, dal;
    logic [7:0]           ro;

    assign pop      = head_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = st_reg;

    always_comb begin
        v4      = (head.eth == ETH_IPV4);
        v6      = (head.eth == ETH_IPV6);
        tcp_e   = {8'b0, head.tcp};
        pay_e   = {8'b0, head.pay};
        plen    = head.len - pay_e;
        rec_end = 17'd5 + {1'b0, head.rlen};
        ip_ok   = (head.len >= 16'd14) &&
                  ((v4 && head.len >= 16'd34 && head.p23) ||
                   (v6 && head.len >= 16'd54 && head.p20));
        if (!ip_ok) begin
            st = ST_NOT_TCP;
        end else if (head.len < tcp_e + 16'd4) begin
            st = ST_PORTS_CUT;
        end else if (head.dp != port_a && head.sp != port_a &&
                     head.dp != port_b && head.sp != port_b) begin
            st = ST_UNWATCHED;
        end else if (head.len < tcp_e + 16'd20 || pay_e > head.len || plen < 16'd5 ||
                     head.rec_type != REC_HSHAKE || head.ver < VER_MIN ||
                     head.ver > VER_MAX) begin
            st = ST_NO_RECORD;
        end else if ({1'b0, plen} < rec_end || plen < 16'd6) begin
            st = ST_RECORD_CUT;
        end else if (head.ht == HT_CLIENT || head.ht == HT_SERVER) begin
            st = ST_HELLO;
        end else begin
            st = ST_NOT_HELLO;
        end

        is6 = (head.len >= 16'd14) && v6;
        ch  = (st == ST_HELLO) && (head.ht == HT_CLIENT);
        sh  = (st == ST_HELLO) && (head.ht == HT_SERVER);
        sp  = '0;
        dp  = '0;
        sah = '0;
        sal = '0;
        dah = '0;
        dal = '0;
        ro  = '0;
        rl  = '0;
        if (st != ST_NOT_TCP && st != ST_PORTS_CUT) begin
            sp = head.sp;
            dp = head.dp;
        end
        if (st != ST_NOT_TCP) begin
            if (v6) begin
                sah = head.src_hi;
                sal = head.src_lo;
                dah = head.dst_hi;
                dal = head.dst_lo;
            end else begin
                sal = {32'b0, head.src_hi[31:0]};
                dal = {32'b0, head.v4_dst};
            end
        end
        if (st == ST_HELLO || st == ST_RECORD_CUT || st == ST_NOT_HELLO) begin
            ro = head.pay;
            rl = head.rlen;
        end
        data_next = {5'b0, rl, ro, dal, dah, sal, sah, dp, sp, sh, ch, is6};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
            st_reg   <= st;
        end
    end

endmodule
`default_nettype wire

[dv/tls_hello_packet_classifier_unit_test.sv]
// Testbench for tls_hello_packet_classifier_unit: frames of directed and random
// content, a behavioural classifier predicting each result, random stalls both sides.
// Depends on thpc_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tls_hello_packet_classifier_unit_test;
    import thpc_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int BUF_LEN = 300;

    typedef struct {
        logic [2:0]  st;
        logic        v6, ch, sh;
        logic [15:0] sp, dp;
        logic [63:0] sah, sal, dah, dal;
        logic [7:0]  ro;
        logic [15:0] rl;
    } hello_res_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_wr_en = 0;
    logic [7:0] s_tdata = 0;
    logic [1:0] cfg_index = 0;
    logic [15:0] cfg_wdata = 0;
    logic s_tready, m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;

    tls_hello_packet_classifier_unit uut (.*);

    initial forever #2 aclk = ~aclk;

    // classifier state mirrored from the block
    logic [7:0]  hdr [0:255];
    int          byte_cnt;
    logic [15:0] port_a, port_b;
    hello_res_t  cls;
    hello_res_t  hello_q[$];

    logic [7:0] fb [0:BUF_LEN-1];
    int  nlen;
    bit  no_idle;
    int  hold_cycles, wait_cnt;
    int  mismatches, results_seen, frames_sent, hellos_seen;

    function automatic logic [7:0] hb(int i);
        return (i < 256) ? hdr[i] : 8'h00;
    endfunction

    function automatic logic [15:0] hw(int i);
        return {hb(i), hb(i + 1)};
    endfunction

    function automatic logic [63:0] hq(int i);
        logic [63:0] v;
        v = 0;
        for (int k = 0; k < 8; k++) v = {v[55:0], hb(i + k)};
        return v;
    endfunction

    function automatic status_t classify_stage(int len);
        int tcp, pay, plen;
        logic [15:0] eth, ver, rlen;
        logic [7:0] ht;
        if (len < 14) return ST_NOT_TCP;
        eth = hw(12);
        cls.v6 = (eth == ETH_IPV6);
        if (eth == ETH_IPV4) begin
            if (len < 34 || hb(23) != PROTO_TCP) return ST_NOT_TCP;
            cls.sal = {32'h0, hb(26), hb(27), hb(28), hb(29)};
            cls.dal = {32'h0, hb(30), hb(31), hb(32), hb(33)};
            tcp = 14 + (hb(14) & 8'h0F) * 4;
        end else if (cls.v6) begin
            if (len < 54 || hb(20) != PROTO_TCP) return ST_NOT_TCP;
            cls.sah = hq(22);
            cls.sal = hq(30);
            cls.dah = hq(38);
            cls.dal = hq(46);
            tcp = 54;
        end else begin
            return ST_NOT_TCP;
        end
        if (len < tcp + 4) return ST_PORTS_CUT;
        cls.sp = hw(tcp);
        cls.dp = hw(tcp + 2);
        if (cls.dp != port_a && cls.sp != port_a && cls.dp != port_b && cls.sp != port_b)
            return ST_UNWATCHED;
        if (len < tcp + 20) return ST_NO_RECORD;
        pay = tcp + ((hb(tcp + 12) >> 4) & 8'h0F) * 4;
        if (pay > len) return ST_NO_RECORD;
        plen = len - pay;
        if (plen < 5 || hb(pay) != REC_HSHAKE) return ST_NO_RECORD;
        ver = hw(pay + 1);
        if (ver < VER_MIN || ver > VER_MAX) return ST_NO_RECORD;
        rlen = hw(pay + 3);
        cls.ro = pay[7:0];
        cls.rl = rlen;
        if (plen < 5 + int'(rlen) || plen < 6) return ST_RECORD_CUT;
        ht = hb(pay + 5);
        if (ht == HT_CLIENT) begin
            cls.ch = 1;
            return ST_HELLO;
        end
        if (ht == HT_SERVER) begin
            cls.sh = 1;
            return ST_HELLO;
        end
        return ST_NOT_HELLO;
    endfunction

    task automatic note_byte(logic [7:0] d, logic l);
        status_t st;
        if (byte_cnt < 256) hdr[byte_cnt] = d;
        if (byte_cnt < int'(MAX_FRAME_BYTES)) byte_cnt++;
        if (!l) return;
        cls = '{default: 0};
        st = classify_stage(byte_cnt);
        cls.st = st;
        if (st != ST_HELLO) begin
            cls.ch = 0;
            cls.sh = 0;
        end
        if (st != ST_HELLO && st != ST_RECORD_CUT && st != ST_NOT_HELLO) begin
            cls.ro = 0;
            cls.rl = 0;
        end
        if (st == ST_NOT_TCP || st == ST_PORTS_CUT) begin
            cls.sp = 0;
            cls.dp = 0;
        end
        if (st == ST_NOT_TCP) begin
            cls.sah = 0; cls.sal = 0; cls.dah = 0; cls.dal = 0;
        end
        hello_q.push_back(cls);
        byte_cnt = 0;
        frames_sent++;
    endtask

    task automatic send_byte(logic [7:0] d, logic l);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        note_byte(d, l);
    endtask

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_byte(i < BUF_LEN ? fb[i] : 8'($urandom), i == len - 1);
    endtask

    // Lay out a frame in fb; nlen is its natural length, record included.
    task automatic build_frame(logic [15:0] eth, int ihl, int doff, logic [15:0] sp,
                               logic [15:0] dp, logic [7:0] rtype, logic [15:0] ver,
                               logic [15:0] rlen, logic [7:0] ht);
        int tcp, pay;
        for (int i = 0; i < BUF_LEN; i++) fb[i] = 8'($urandom);
        fb[12] = eth[15:8];
        fb[13] = eth[7:0];
        if (eth == ETH_IPV6) begin
            fb[14] = 8'h60;
            fb[20] = PROTO_TCP;
            tcp = 54;
        end else begin
            fb[14] = {4'h4, 4'(ihl)};
            fb[23] = PROTO_TCP;
            tcp = 14 + ihl * 4;
        end
        fb[tcp] = sp[15:8]; fb[tcp + 1] = sp[7:0];
        fb[tcp + 2] = dp[15:8]; fb[tcp + 3] = dp[7:0];
        fb[tcp + 12] = {4'(doff), fb[tcp + 12][3:0]};
        pay = tcp + doff * 4;
        fb[pay] = rtype;
        fb[pay + 1] = ver[15:8]; fb[pay + 2] = ver[7:0];
        fb[pay + 3] = rlen[15:8]; fb[pay + 4] = rlen[7:0];
        fb[pay + 5] = ht;
        nlen = pay + 5 + rlen;
        if (nlen > BUF_LEN) nlen = BUF_LEN;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        s_tvalid <= 0;
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        if (idx == CFG_PORT_A) port_a = val;
        else if (idx == CFG_PORT_B) port_b = val;
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (hello_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, e, a);
        end
    endtask

    always @(posedge aclk) begin
        hello_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (hello_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result transfer with none outstanding");
            end else begin
                e = hello_q.pop_front();
                if (e.st == ST_HELLO) hellos_seen++;
                check_field("status", e.st, m_tuser);
                check_field("is_ipv6", e.v6, m_tdata[0]);
                check_field("client_hello", e.ch, m_tdata[1]);
                check_field("server_hello", e.sh, m_tdata[2]);
                check_field("source_port", e.sp, m_tdata[18:3]);
                check_field("dest_port", e.dp, m_tdata[34:19]);
                check_field("source_addr_high", e.sah, m_tdata[98:35]);
                check_field("source_addr_low", e.sal, m_tdata[162:99]);
                check_field("dest_addr_high", e.dah, m_tdata[226:163]);
                check_field("dest_addr_low", e.dal, m_tdata[290:227]);
                check_field("record_offset", e.ro, m_tdata[298:291]);
                check_field("record_length", e.rl, m_tdata[314:299]);
            end
            wait_cnt = no_idle ? 0 : $urandom_range(0, 18);
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 0;
        end else if (wait_cnt > 0) begin
            wait_cnt--;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic test_directed;
        // minimal and sub-header frames, unknown ethertype
        for (int i = 0; i < BUF_LEN; i++) fb[i] = 8'hFF;
        send_frame(1);
        for (int i = 0; i < BUF_LEN; i++) fb[i] = 8'h00;
        send_frame(13);
        send_frame(60);
        // IPv4 carrying something other than TCP
        build_frame(ETH_IPV4, 5, 5, 443, 1000, REC_HSHAKE, VER_MIN, 10, HT_CLIENT);
        fb[23] = 8'd17;
        send_frame(nlen);
        // ports cut, then unwatched
        build_frame(ETH_IPV4, 5, 5, 443, 1000, REC_HSHAKE, VER_MIN, 10, HT_CLIENT);
        send_frame(36);
        build_frame(ETH_IPV4, 5, 5, 1, 2, REC_HSHAKE, VER_MIN, 10, HT_CLIENT);
        send_frame(nlen);
        // hellos of both kinds, v4 and v6, both ports
        build_frame(ETH_IPV4, 5, 5, 5000, 443, REC_HSHAKE, VER_MIN, 20, HT_CLIENT);
        send_frame(nlen);
        build_frame(ETH_IPV6, 5, 5, 8443, 7, REC_HSHAKE, VER_MAX, 30, HT_SERVER);
        send_frame(nlen);
        build_frame(ETH_IPV4, 15, 15, 443, 443, REC_HSHAKE, 16'h0303, 40, HT_SERVER);
        send_frame(nlen);
        // versions just outside the range, wrong record type
        build_frame(ETH_IPV4, 5, 5, 443, 9, REC_HSHAKE, 16'h02FF, 8, HT_CLIENT);
        send_frame(nlen);
        build_frame(ETH_IPV6, 5, 5, 443, 9, REC_HSHAKE, 16'h0305, 8, HT_CLIENT);
        send_frame(nlen);
        build_frame(ETH_IPV4, 5, 5, 443, 9, 8'h17, VER_MIN, 8, HT_CLIENT);
        send_frame(nlen);
        // record cut, zero length with no type byte, not a hello
        build_frame(ETH_IPV4, 5, 5, 443, 9, REC_HSHAKE, VER_MIN, 30, HT_CLIENT);
        send_frame(nlen - 1);
        build_frame(ETH_IPV4, 5, 5, 443, 9, REC_HSHAKE, VER_MIN, 0, HT_CLIENT);
        send_frame(59);
        build_frame(ETH_IPV4, 5, 5, 443, 9, REC_HSHAKE, VER_MIN, 4, 8'hFF);
        send_frame(nlen);
        // payload start beyond the frame end, short IHL, zero data offset
        build_frame(ETH_IPV4, 5, 15, 443, 9, REC_HSHAKE, VER_MIN, 4, HT_CLIENT);
        send_frame(60);
        build_frame(ETH_IPV4, 0, 5, 443, 9, REC_HSHAKE, VER_MIN, 4, HT_CLIENT);
        send_frame(nlen);
        build_frame(ETH_IPV4, 2, 0, 443, 9, REC_HSHAKE, VER_MIN, 4, HT_CLIENT);
        send_frame(80);
        drain();
    endtask

    task automatic random_frame;
        int r, kind;
        logic [15:0] eth, sp, dp;
        r = $urandom_range(0, 99);
        eth = $urandom_range(0, 1) ? ETH_IPV6 : ETH_IPV4;
        sp = 16'($urandom);
        dp = 16'($urandom);
        case ($urandom_range(0, 3))
            0: sp = port_a;
            1: dp = port_a;
            2: sp = port_b;
            default: dp = port_b;
        endcase
        build_frame(eth, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 5,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 5, sp, dp,
                    REC_HSHAKE, VER_MIN + 16'($urandom_range(0, 4)),
                    16'($urandom_range(0, 40)),
                    $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(1, 2)));
        if (r >= 70 && r < 85) begin
            kind = $urandom_range(0, 3);
            if (kind == 0) fb[$urandom_range(12, 13)] = 8'($urandom);
            else if (kind == 1) fb[eth == ETH_IPV6 ? 20 : 23] = 8'($urandom);
            else if (kind == 2) fb[$urandom_range(14, 120)] = 8'($urandom);
            else nlen = nlen + $urandom_range(0, BUF_LEN - nlen);
        end else if (r >= 85) begin
            nlen = $urandom_range(1, nlen);
        end
        send_frame(nlen);
    endtask

    task automatic test_random(int frames);
        for (int i = 0; i < frames; i++) begin
            if (i % 10 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_frame();
        end
        no_idle = 0;
        drain();
    endtask

    task automatic test_ports;
        write_reg(CFG_PORT_A, 16'h0000);
        write_reg(CFG_PORT_B, 16'hFFFF);
        write_reg(CFG_SPARE, 16'h1234);
        test_random(1);
        write_reg(CFG_PORT_A, 16'hFFFF);
        write_reg(CFG_PORT_B, 16'h0000);
        test_random(1);
        write_reg(CFG_PORT_A, 16'($urandom));
        write_reg(CFG_PORT_B, 16'($urandom));
        test_random(1);
        write_reg(CFG_PORT_A, PORT_A_RST);
        write_reg(CFG_PORT_B, PORT_B_RST);
    endtask

    task automatic test_backpressure;
        no_idle = 1;
        hold_cycles = 400;
        for (int i = 0; i < 6; i++) begin
            build_frame(ETH_IPV4, 5, 5, 443, 1, REC_HSHAKE, VER_MIN, 0, HT_CLIENT);
            send_frame(20);
        end
        no_idle = 0;
        drain();
    endtask

    task automatic test_long_frame;
        no_idle = 1;
        build_frame(ETH_IPV6, 5, 5, 443, 1, REC_HSHAKE, VER_MIN, 40, HT_SERVER);
        send_frame(BUF_LEN);
        no_idle = 0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < 256; i++) hdr[i] = 0;
        byte_cnt = 0;
        port_a = PORT_A_RST;
        port_b = PORT_B_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        repeat (4) @(posedge aclk);
        test_directed();
        test_random(4);
        test_ports();
        test_backpressure();
        test_long_frame();
        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d frames, %0d results (%0d hellos), port settings incl. extremes,",
                 frames_sent, results_seen, hellos_seen);
        $display("long receiver hold-off and a frame longer than the header store");
        if (mismatches == 0 && hello_q.size() == 0) begin
            $display("tls_hello_packet_classifier_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, hello_q.size());
            $display("tls_hello_packet_classifier_unit verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tls_hello_packet_classifier_unit verification failed");
        $finish;
    end

endmodule
